### hw/rtl/triangle_corner_normals_top_defines.svh
// assertion macros shared by the triangle corner normals rtl
// needs clk_i in the scope of each use, and rst_ni for TCN_ASSERT
`ifndef TRIANGLE_CORNER_NORMALS_TOP_DEFINES_SVH
`define TRIANGLE_CORNER_NORMALS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define TCN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define TCN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCN_ASSERT(lbl, prop, msg)
`define TCN_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/tcn_pkg.sv
// shared types and constants of the triangle corner normals block
// no dependencies
`timescale 1ns / 1ps

package tcn_pkg;

  localparam int COORD_W     = 16;
  localparam int EDGE_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * EDGE_W;
  localparam int NORMAL_W    = PROD_W + 1;
  localparam int INDEX_W     = 16;
  localparam int QUEUE_DEPTH = 2;

  // edge vector, two's complement components
  typedef struct packed {
    logic [EDGE_W-1:0] x;
    logic [EDGE_W-1:0] y;
    logic [EDGE_W-1:0] z;
  } vec_t;

  // one classified triangle as held in the queue
  typedef struct packed {
    vec_t               ab;
    vec_t               ac;
    vec_t               bc;
    logic [INDEX_W-1:0] idx_a;
    logic [INDEX_W-1:0] idx_b;
    logic [INDEX_W-1:0] idx_c;
  } tri_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    CORNER_A = 3'b001,
    CORNER_B = 3'b010,
    CORNER_C = 3'b100
  } corner_e;

endpackage

### hw/rtl/tcn_front.sv
// front end: takes a triangle request, forms the edge vectors ab, ac and bc, registers them
// depends on tcn_pkg
`timescale 1ns / 1ps

module tcn_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tcn_pkg::COORD_W-1:0] a_x_i,
  input  logic [tcn_pkg::COORD_W-1:0] a_y_i,
  input  logic [tcn_pkg::COORD_W-1:0] a_z_i,
  input  logic [tcn_pkg::COORD_W-1:0] b_x_i,
  input  logic [tcn_pkg::COORD_W-1:0] b_y_i,
  input  logic [tcn_pkg::COORD_W-1:0] b_z_i,
  input  logic [tcn_pkg::COORD_W-1:0] c_x_i,
  input  logic [tcn_pkg::COORD_W-1:0] c_y_i,
  input  logic [tcn_pkg::COORD_W-1:0] c_z_i,
  input  logic [tcn_pkg::INDEX_W-1:0] index_a_i,
  input  logic [tcn_pkg::INDEX_W-1:0] index_b_i,
  input  logic [tcn_pkg::INDEX_W-1:0] index_c_i,
  input  tcn_pkg::queue_status_t      q_status_i,
  output logic                        push_o,
  output tcn_pkg::tri_t               push_data_o
);
  import tcn_pkg::*;

  logic  vld_q, vld_d;
  tri_t  tri_q, tri_d;
  logic  accept;

  // sign-extend both corners, difference wraps correctly in EDGE_W bits
  function automatic logic [EDGE_W-1:0] sub_ext(logic [COORD_W-1:0] p,
                                                logic [COORD_W-1:0] q);
    return {p[COORD_W-1], p} - {q[COORD_W-1], q};
  endfunction

  assign push_o      = vld_q && !q_status_i.full;
  assign push_data_o = tri_q;
  assign in_stall_o  = vld_q && !push_o;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    tri_d      = tri_q;
    tri_d.ab.x = sub_ext(a_x_i, b_x_i);
    tri_d.ab.y = sub_ext(a_y_i, b_y_i);
    tri_d.ab.z = sub_ext(a_z_i, b_z_i);
    tri_d.ac.x = sub_ext(a_x_i, c_x_i);
    tri_d.ac.y = sub_ext(a_y_i, c_y_i);
    tri_d.ac.z = sub_ext(a_z_i, c_z_i);
    tri_d.bc.x = sub_ext(b_x_i, c_x_i);
    tri_d.bc.y = sub_ext(b_y_i, c_y_i);
    tri_d.bc.z = sub_ext(b_z_i, c_z_i);
    tri_d.idx_a = index_a_i;
    tri_d.idx_b = index_b_i;
    tri_d.idx_c = index_c_i;
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tri_q <= tri_d;
    end
  end

endmodule

### hw/rtl/tcn_queue.sv
// short queue of classified triangles between front and back
// depends on tcn_pkg and triangle_corner_normals_top_defines.svh
`timescale 1ns / 1ps

`include "triangle_corner_normals_top_defines.svh"

module tcn_queue #(
  parameter int Depth = tcn_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tcn_pkg::tri_t          push_data_i,
  input  logic                   pop_i,
  output tcn_pkg::tri_t          head_o,
  output tcn_pkg::queue_status_t status_o
);
  import tcn_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tri_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;

  assign full            = (count_q == CntW'(Depth));
  assign empty           = (count_q == '0);
  assign status_o.full   = full;
  assign status_o.empty  = empty;
  assign head_o          = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TCN_ASSERT(a_no_overflow, !(push_i && full), "push into a full queue")
  `TCN_ASSERT(a_no_underflow, !(pop_i && empty), "pop from an empty queue")
  `TCN_ASSERT(a_count_step, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1),
              "queue count did not follow a push")

endmodule

### hw/rtl/tcn_back.sv
// back end: walks corners a, b, c of the head triangle, multiplies, then subtracts
// depends on tcn_pkg and triangle_corner_normals_top_defines.svh
`timescale 1ns / 1ps

`include "triangle_corner_normals_top_defines.svh"

module tcn_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcn_pkg::tri_t                head_i,
  input  tcn_pkg::queue_status_t       q_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcn_pkg::INDEX_W-1:0]  vertex_index_o,
  output logic [tcn_pkg::NORMAL_W-1:0] normal_x_o,
  output logic [tcn_pkg::NORMAL_W-1:0] normal_y_o,
  output logic [tcn_pkg::NORMAL_W-1:0] normal_z_o,
  output logic                         last_corner_o
);
  import tcn_pkg::*;

  corner_e corner_q, corner_d;
  vec_t    u, w;
  logic [INDEX_W-1:0] idx_sel;

  // product stage
  logic                     p_vld_q, p_vld_d;
  logic signed [PROD_W-1:0] p_q [6];
  logic signed [PROD_W-1:0] p_d [6];
  logic [INDEX_W-1:0]       p_idx_q;
  logic                     p_last_q;

  // output stage
  logic                     o_vld_q, o_vld_d;
  logic [INDEX_W-1:0]       o_idx_q;
  logic [NORMAL_W-1:0]      o_x_q, o_y_q, o_z_q;
  logic                     o_last_q;

  logic o_ready, p_ready, issue;

  assign o_ready = !o_vld_q || !out_stall_i;
  assign p_ready = !p_vld_q || o_ready;
  assign issue   = !q_status_i.empty && p_ready;
  assign pop_o   = issue && (corner_q == CORNER_C);

  always_comb begin
    u        = head_i.ab;
    w        = head_i.ac;
    idx_sel  = head_i.idx_a;
    corner_d = corner_q;
    case (corner_q)
      CORNER_A: begin
        u        = head_i.ab;
        w        = head_i.ac;
        idx_sel  = head_i.idx_a;
        corner_d = CORNER_B;
      end
      CORNER_B: begin
        u        = head_i.ab;
        w        = head_i.bc;
        idx_sel  = head_i.idx_b;
        corner_d = CORNER_C;
      end
      CORNER_C: begin
        u        = head_i.ac;
        w        = head_i.bc;
        idx_sel  = head_i.idx_c;
        corner_d = CORNER_A;
      end
      default: begin
        corner_d = CORNER_A;
      end
    endcase
    if (!issue) begin
      corner_d = corner_q;
    end
  end

  // the six partial products of the cross product
  always_comb begin
    p_d[0] = $signed(u.y) * $signed(w.z);
    p_d[1] = $signed(u.z) * $signed(w.y);
    p_d[2] = $signed(u.z) * $signed(w.x);
    p_d[3] = $signed(u.x) * $signed(w.z);
    p_d[4] = $signed(u.x) * $signed(w.y);
    p_d[5] = $signed(u.y) * $signed(w.x);
  end

  always_comb begin
    p_vld_d = p_vld_q;
    if (p_ready) begin
      p_vld_d = issue;
    end
    o_vld_d = o_vld_q;
    if (o_ready) begin
      o_vld_d = p_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= CORNER_A;
      p_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      corner_q <= corner_d;
      p_vld_q  <= p_vld_d;
      o_vld_q  <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_q      <= p_d;
      p_idx_q  <= idx_sel;
      p_last_q <= (corner_q == CORNER_C);
    end
    if (o_ready && p_vld_q) begin
      o_idx_q  <= p_idx_q;
      o_x_q    <= {p_q[0][PROD_W-1], p_q[0]} - {p_q[1][PROD_W-1], p_q[1]};
      o_y_q    <= {p_q[2][PROD_W-1], p_q[2]} - {p_q[3][PROD_W-1], p_q[3]};
      o_z_q    <= {p_q[4][PROD_W-1], p_q[4]} - {p_q[5][PROD_W-1], p_q[5]};
      o_last_q <= p_last_q;
    end
  end

  assign out_valid_o    = o_vld_q;
  assign vertex_index_o = o_idx_q;
  assign normal_x_o     = o_x_q;
  assign normal_y_o     = o_y_q;
  assign normal_z_o     = o_z_q;
  assign last_corner_o  = o_last_q;

  `TCN_ASSERT(a_pop_on_corner_c, pop_o |-> (issue && corner_q == CORNER_C),
              "triangle popped before its third corner")
  `TCN_ASSERT(a_issue_fills_stage,
              issue |=> (p_vld_q && (p_last_q == ($past(corner_q) == CORNER_C))),
              "product stage lost an issued corner")
  `TCN_ASSERT(a_corner_holds, !issue |=> (corner_q == $past(corner_q)),
              "corner sequencer moved without an issue")

endmodule

### hw/rtl/triangle_corner_normals_top.sv
// top level of the triangle corner normals block: front, queue, back
// depends on tcn_pkg, tcn_front, tcn_queue, tcn_back
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   a/b/c x,y,z and index_a/b/c
// out      output     out_valid_o / out_stall_i vertex_index, normal_x/y/z, last_corner
//
// each triangle gives three results, corners a, b, c, one per cycle while the queue is
// not empty and the output is not stalled, from the single multiplier bank in the back end.
// a request passes the front register, the queue, the product register and the output register.
// reset clears only the valid bits, queue pointers and count, and corner sequencer.
// a stalled output holds its result; the queue lets the front keep taking requests until it is full.
`timescale 1ns / 1ps

module triangle_corner_normals_top #(
  parameter int QueueDepth = tcn_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcn_pkg::COORD_W-1:0]  a_x_i,
  input  logic [tcn_pkg::COORD_W-1:0]  a_y_i,
  input  logic [tcn_pkg::COORD_W-1:0]  a_z_i,
  input  logic [tcn_pkg::COORD_W-1:0]  b_x_i,
  input  logic [tcn_pkg::COORD_W-1:0]  b_y_i,
  input  logic [tcn_pkg::COORD_W-1:0]  b_z_i,
  input  logic [tcn_pkg::COORD_W-1:0]  c_x_i,
  input  logic [tcn_pkg::COORD_W-1:0]  c_y_i,
  input  logic [tcn_pkg::COORD_W-1:0]  c_z_i,
  input  logic [tcn_pkg::INDEX_W-1:0]  index_a_i,
  input  logic [tcn_pkg::INDEX_W-1:0]  index_b_i,
  input  logic [tcn_pkg::INDEX_W-1:0]  index_c_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcn_pkg::INDEX_W-1:0]  vertex_index_o,
  output logic [tcn_pkg::NORMAL_W-1:0] normal_x_o,
  output logic [tcn_pkg::NORMAL_W-1:0] normal_y_o,
  output logic [tcn_pkg::NORMAL_W-1:0] normal_z_o,
  output logic                         last_corner_o
);
  import tcn_pkg::*;

  queue_status_t q_status;
  logic          push, pop;
  tri_t          push_data, head;

  tcn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_z_i       (a_z_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_z_i       (b_z_i),
    .c_x_i       (c_x_i),
    .c_y_i       (c_y_i),
    .c_z_i       (c_z_i),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .index_c_i   (index_c_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tcn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  tcn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_index_o (vertex_index_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .last_corner_o  (last_corner_o)
  );

endmodule
